FILE: src/pmru_pkg.sv
// pmru_pkg: shared constants, tables and types for the projection matrix
// rigid update unit. No dependencies.
package pmru_pkg;

    localparam int DIV_BITS          = 48;
    localparam int PITCH_W           = 24;
    localparam int DIM_W             = 13;
    localparam int CFG_IDX_W         = 2;
    localparam int CORDIC_STAGES_DEF = 24;
    localparam int QUEUE_DEPTH       = 4;
    localparam int ANG_W             = 34;
    localparam int XY_W              = 33;

    localparam logic [CFG_IDX_W-1:0] CFG_COLS  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_ROWS  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_PITCH = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE = 2'd3;

    localparam logic [DIM_W-1:0]   COLS_RESET  = 13'd1024;
    localparam logic [DIM_W-1:0]   ROWS_RESET  = 13'd1024;
    localparam logic [PITCH_W-1:0] PITCH_RESET = 24'd6554;

    localparam logic signed [ANG_W-1:0] Q30_PI      = 34'sd3373259426;
    localparam logic signed [ANG_W-1:0] Q30_HALF_PI = 34'sd1686629713;
    localparam logic signed [XY_W-1:0]  GAIN_INV    = 33'sd652032874;

    localparam logic [31:0] ATAN_Q30 [32] = '{
        32'h3243F6A8, 32'h1DAC6705, 32'h0FADBAFC, 32'h07F56EA6, 32'h03FEAB76, 32'h01FFD55B,
        32'h00FFFAAA, 32'h007FFF55, 32'h003FFFEA, 32'h001FFFFD, 32'h000FFFFF, 32'h0007FFFF,
        32'h0003FFFF, 32'h0001FFFF, 32'h0000FFFF, 32'h00007FFF, 32'h00003FFF, 32'h00001FFF,
        32'h00000FFF, 32'h000007FF, 32'h000003FF, 32'h000001FF, 32'h000000FF, 32'h0000007F,
        32'h0000003F, 32'h0000001F, 32'h0000000F, 32'h00000008, 32'h00000004, 32'h00000002,
        32'h00000001, 32'h00000000
    };

    typedef struct packed {
        logic [DIV_BITS-1:0]     mag_u;
        logic                    neg_u;
        logic [DIV_BITS-1:0]     mag_v;
        logic                    neg_v;
        logic signed [ANG_W-1:0] z;
        logic                    flip;
        logic signed [47:0]      top;
        logic signed [47:0]      mid;
        logic signed [47:0]      bot;
    } work_t;

    typedef struct packed {
        logic [DIM_W-1:0]   cols;
        logic [DIM_W-1:0]   rows;
        logic [PITCH_W-1:0] pitch;
    } cfg_t;

endpackage

FILE: src/projection_matrix_rigid_update_unit.sv
// Path from input acceptance to out_valid: input register, queue slot, 48-stage
// restoring divider, 7 multiply/round stages; CORDIC is padded to the divider depth.
// Throughput: one column per cycle while out_stall does not hold the back pipeline.
// The whole back pipeline holds while a result waits on out_stall; the queue absorbs 4.
// Reset clears valid bits and queue pointers and loads the register defaults; no sweep.
module projection_matrix_rigid_update_unit #(
    parameter int CORDIC_STAGES = pmru_pkg::CORDIC_STAGES_DEF
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 in_valid,
    output logic                                 in_stall,
    input  logic signed [31:0]                   shift_u,
    input  logic signed [31:0]                   shift_v,
    input  logic signed [15:0]                   rot_angle,
    input  logic signed [47:0]                   column_top,
    input  logic signed [47:0]                   column_mid,
    input  logic signed [47:0]                   column_bottom,
    output logic                                 out_valid,
    input  logic                                 out_stall,
    output logic signed [47:0]                   new_top,
    output logic signed [47:0]                   new_mid,
    output logic signed [47:0]                   new_bottom,
    input  logic                                 cfg_valid,
    output logic                                 cfg_ready,
    input  logic [pmru_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [pmru_pkg::PITCH_W-1:0]         cfg_data
);

    logic [pmru_pkg::DIM_W-1:0]   cols_reg;
    logic [pmru_pkg::DIM_W-1:0]   rows_reg;
    logic [pmru_pkg::PITCH_W-1:0] pitch_reg;
    pmru_pkg::cfg_t               cfg;
    logic                         push;
    pmru_pkg::work_t              push_item;
    logic                         queue_full;
    logic                         head_valid;
    pmru_pkg::work_t              head_item;
    logic                         pop;

    assign cfg_ready = 1'b1;
    assign cfg.cols  = cols_reg;
    assign cfg.rows  = rows_reg;
    assign cfg.pitch = pitch_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cols_reg  <= pmru_pkg::COLS_RESET;
            rows_reg  <= pmru_pkg::ROWS_RESET;
            pitch_reg <= pmru_pkg::PITCH_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                pmru_pkg::CFG_COLS:  cols_reg  <= cfg_data[pmru_pkg::DIM_W-1:0];
                pmru_pkg::CFG_ROWS:  rows_reg  <= cfg_data[pmru_pkg::DIM_W-1:0];
                pmru_pkg::CFG_PITCH: pitch_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    pmru_front u_front (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .shift_u       (shift_u),
        .shift_v       (shift_v),
        .rot_angle     (rot_angle),
        .column_top    (column_top),
        .column_mid    (column_mid),
        .column_bottom (column_bottom),
        .queue_full    (queue_full),
        .push          (push),
        .push_item     (push_item)
    );

    pmru_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_item  (push_item),
        .full       (queue_full),
        .head_valid (head_valid),
        .head_item  (head_item),
        .pop        (pop)
    );

    pmru_back #(.CORDIC_STAGES(CORDIC_STAGES)) u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg),
        .head_valid (head_valid),
        .head_item  (head_item),
        .pop        (pop),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .new_top    (new_top),
        .new_mid    (new_mid),
        .new_bottom (new_bottom)
    );

endmodule

FILE: src/pmru_front.sv
// pmru_front: input register stage; folds the angle and splits the shifts
// into sign and magnitude. Depends on pmru_pkg.
module pmru_front (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_stall,
    input  logic signed [31:0]  shift_u,
    input  logic signed [31:0]  shift_v,
    input  logic signed [15:0]  rot_angle,
    input  logic signed [47:0]  column_top,
    input  logic signed [47:0]  column_mid,
    input  logic signed [47:0]  column_bottom,
    input  logic                queue_full,
    output logic                push,
    output pmru_pkg::work_t     push_item
);

    logic                             front_vld_reg;
    pmru_pkg::work_t                  item_reg;
    pmru_pkg::work_t                  cls;
    logic [31:0]                      su_abs;
    logic [31:0]                      sv_abs;
    logic signed [pmru_pkg::ANG_W-1:0] z0;

    always_comb
    begin
        su_abs = shift_u[31] ? 32'(-shift_u) : 32'(shift_u);
        sv_abs = shift_v[31] ? 32'(-shift_v) : 32'(shift_v);
        z0     = pmru_pkg::ANG_W'(rot_angle) <<< 17;
        cls.mag_u = {su_abs, 16'd0};
        cls.neg_u = shift_u[31];
        cls.mag_v = {sv_abs, 16'd0};
        cls.neg_v = shift_v[31];
        cls.top   = column_top;
        cls.mid   = column_mid;
        cls.bot   = column_bottom;
        if (z0 > pmru_pkg::Q30_HALF_PI)
        begin
            cls.z    = z0 - pmru_pkg::Q30_PI;
            cls.flip = 1'b1;
        end
        else if (z0 < -pmru_pkg::Q30_HALF_PI)
        begin
            cls.z    = z0 + pmru_pkg::Q30_PI;
            cls.flip = 1'b1;
        end
        else
        begin
            cls.z    = z0;
            cls.flip = 1'b0;
        end
    end

    assign in_stall  = front_vld_reg && queue_full;
    assign push      = front_vld_reg && !queue_full;
    assign push_item = item_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            front_vld_reg <= 1'b0;
        else if (!in_stall)
            front_vld_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (!in_stall && in_valid)
            item_reg <= cls;
    end

endmodule

FILE: src/pmru_queue.sv
// pmru_queue: short request queue between front and back.
// Depends on pmru_pkg.
module pmru_queue (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            push,
    input  pmru_pkg::work_t push_item,
    output logic            full,
    output logic            head_valid,
    output pmru_pkg::work_t head_item,
    input  logic            pop
);

    localparam int PW = $clog2(pmru_pkg::QUEUE_DEPTH);
    localparam int CW = $clog2(pmru_pkg::QUEUE_DEPTH + 1);

    pmru_pkg::work_t mem_reg [pmru_pkg::QUEUE_DEPTH];
    logic [PW-1:0]   wr_ptr_reg;
    logic [PW-1:0]   rd_ptr_reg;
    logic [CW-1:0]   count_reg;
    logic [CW-1:0]   count_next;

    assign full       = count_reg == CW'(pmru_pkg::QUEUE_DEPTH);
    assign head_valid = count_reg != '0;
    assign head_item  = mem_reg[rd_ptr_reg];

    always_comb
    begin
        case ({push, pop})
            2'b10:   count_next = CW'(count_reg + 1'b1);
            2'b01:   count_next = CW'(count_reg - 1'b1);
            default: count_next = count_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= PW'(wr_ptr_reg + 1'b1);
            if (pop)
                rd_ptr_reg <= PW'(rd_ptr_reg + 1'b1);
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            mem_reg[wr_ptr_reg] <= push_item;
    end

    assert property (@(posedge clk) disable iff (!rst_n) pop |-> head_valid)
        else $error("queue popped while empty");
    assert property (@(posedge clk) disable iff (!rst_n) push |-> !full)
        else $error("queue pushed while full");
    assert property (@(posedge clk) disable iff (!rst_n)
        (push && !pop) |=> count_reg == CW'($past(count_reg) + 1'b1))
        else $error("queue count lost a push");

endmodule

FILE: src/pmru_div.sv
// pmru_div: pipelined restoring divider, one quotient bit per stage.
// Depends on pmru_pkg.
module pmru_div (
    input  logic                              clk,
    input  logic                              adv,
    input  logic [pmru_pkg::DIV_BITS-1:0]     dividend,
    input  logic [pmru_pkg::PITCH_W-1:0]      divisor,
    output logic [pmru_pkg::DIV_BITS-1:0]     quotient
);

    localparam int N  = pmru_pkg::DIV_BITS;
    localparam int RW = pmru_pkg::PITCH_W;

    logic [RW-1:0] rem_reg [1:N-1];
    logic [N-1:0]  num_reg [1:N];
    logic [RW-1:0] rem_in  [0:N-1];
    logic [N-1:0]  num_in  [0:N-1];
    logic [RW:0]   trial   [0:N-1];
    logic          ge      [0:N-1];
    logic [RW-1:0] rem_out [0:N-1];
    logic [N-1:0]  num_out [0:N-1];

    always_comb
    begin
        rem_in[0] = '0;
        num_in[0] = dividend;
        for (int k = 1; k < N; k++)
        begin
            rem_in[k] = rem_reg[k];
            num_in[k] = num_reg[k];
        end
        for (int k = 0; k < N; k++)
        begin
            trial[k]   = {rem_in[k], num_in[k][N-1]};
            ge[k]      = trial[k] >= {1'b0, divisor};
            rem_out[k] = ge[k] ? RW'(trial[k] - {1'b0, divisor}) : trial[k][RW-1:0];
            num_out[k] = {num_in[k][N-2:0], ge[k]};
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            for (int k = 0; k < N - 1; k++)
                rem_reg[k+1] <= rem_out[k];
            for (int k = 0; k < N; k++)
                num_reg[k+1] <= num_out[k];
        end
    end

    assign quotient = num_reg[N];

endmodule

FILE: src/pmru_cordic.sv
// pmru_cordic: pipelined rotation-mode CORDIC, one micro-rotation per stage.
// Depends on pmru_pkg.
module pmru_cordic #(
    parameter int STAGES = pmru_pkg::CORDIC_STAGES_DEF
) (
    input  logic                               clk,
    input  logic                               adv,
    input  logic signed [pmru_pkg::ANG_W-1:0]  z_in,
    output logic signed [pmru_pkg::XY_W-1:0]   x_out,
    output logic signed [pmru_pkg::XY_W-1:0]   y_out
);

    localparam int AW = pmru_pkg::ANG_W;
    localparam int XW = pmru_pkg::XY_W;

    logic signed [XW-1:0] x_reg [1:STAGES];
    logic signed [XW-1:0] y_reg [1:STAGES];
    logic signed [AW-1:0] z_reg [1:STAGES-1];
    logic signed [XW-1:0] x_cur [0:STAGES-1];
    logic signed [XW-1:0] y_cur [0:STAGES-1];
    logic signed [AW-1:0] z_cur [0:STAGES-1];
    logic signed [XW-1:0] x_nxt [0:STAGES-1];
    logic signed [XW-1:0] y_nxt [0:STAGES-1];
    logic signed [AW-1:0] z_nxt [0:STAGES-1];
    logic signed [AW-1:0] atan  [0:STAGES-1];

    always_comb
    begin
        x_cur[0] = pmru_pkg::GAIN_INV;
        y_cur[0] = '0;
        z_cur[0] = z_in;
        for (int i = 1; i < STAGES; i++)
        begin
            x_cur[i] = x_reg[i];
            y_cur[i] = y_reg[i];
            z_cur[i] = z_reg[i];
        end
        for (int i = 0; i < STAGES; i++)
        begin
            atan[i] = $signed({2'b00, pmru_pkg::ATAN_Q30[i]});
            if (!z_cur[i][AW-1])
            begin
                x_nxt[i] = x_cur[i] - (y_cur[i] >>> i);
                y_nxt[i] = y_cur[i] + (x_cur[i] >>> i);
                z_nxt[i] = z_cur[i] - atan[i];
            end
            else
            begin
                x_nxt[i] = x_cur[i] + (y_cur[i] >>> i);
                y_nxt[i] = y_cur[i] - (x_cur[i] >>> i);
                z_nxt[i] = z_cur[i] + atan[i];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            for (int i = 0; i < STAGES; i++)
            begin
                x_reg[i+1] <= x_nxt[i];
                y_reg[i+1] <= y_nxt[i];
            end
            for (int i = 0; i < STAGES - 1; i++)
                z_reg[i+1] <= z_nxt[i];
        end
    end

    assign x_out = x_reg[STAGES];
    assign y_out = y_reg[STAGES];

endmodule

FILE: src/pmru_back.sv
// pmru_back: divider, CORDIC, homography build and column multiply pipeline
// with the output register. Depends on pmru_pkg, pmru_div, pmru_cordic.
module pmru_back #(
    parameter int CORDIC_STAGES = pmru_pkg::CORDIC_STAGES_DEF
) (
    input  logic               clk,
    input  logic               rst_n,
    input  pmru_pkg::cfg_t     cfg,
    input  logic               head_valid,
    input  pmru_pkg::work_t    head_item,
    output logic               pop,
    output logic               out_valid,
    input  logic               out_stall,
    output logic signed [47:0] new_top,
    output logic signed [47:0] new_mid,
    output logic signed [47:0] new_bottom
);

    localparam int N   = pmru_pkg::DIV_BITS;
    localparam int LAT = N + 7;
    localparam int DLY = N - CORDIC_STAGES;
    localparam int XW  = pmru_pkg::XY_W;

    localparam logic signed [85:0]  T_HALF = 86'sd536870912;
    localparam logic signed [121:0] O_HALF = 122'sd536870912;

    typedef struct packed {
        logic               neg_u;
        logic               neg_v;
        logic               flip;
        logic signed [47:0] top;
        logic signed [47:0] mid;
        logic signed [47:0] bot;
    } side_t;

    function automatic logic signed [47:0] sat48(input logic signed [91:0] v);
        logic signed [47:0] r;
        if ((v[91:47] == '0) || (v[91:47] == '1))
            r = v[47:0];
        else if (v[91])
            r = 48'sh8000_0000_0000;
        else
            r = 48'sh7FFF_FFFF_FFFF;
        return r;
    endfunction

    logic                 adv;
    logic                 vld_reg  [1:LAT];
    side_t                side_reg [1:N];
    logic signed [XW-1:0] xd_reg   [1:DLY];
    logic signed [XW-1:0] yd_reg   [1:DLY];
    logic [N-1:0]         q_u;
    logic [N-1:0]         q_v;
    logic signed [XW-1:0] x_c;
    logic signed [XW-1:0] y_c;
    logic [pmru_pkg::PITCH_W-1:0] divisor;
    side_t                sd;
    logic signed [48:0]   tu;
    logic signed [48:0]   tv;
    logic signed [28:0]   uc_s;
    logic signed [28:0]   vc_s;

    // stage A
    logic signed [XW-1:0] a_c_reg, a_s_reg;
    logic signed [49:0]   a_au_reg, a_av_reg;
    logic signed [47:0]   a_top_reg, a_mid_reg, a_bot_reg;
    // stage B
    logic signed [57:0]   b_cauh_reg, b_savh_reg, b_sauh_reg, b_cavh_reg;
    logic signed [58:0]   b_caul_reg, b_savl_reg, b_saul_reg, b_cavl_reg;
    logic signed [XW-1:0] b_c_reg, b_s_reg;
    logic signed [47:0]   b_top_reg, b_mid_reg, b_bot_reg;
    // stage C
    logic signed [83:0]   c_cau_reg, c_sav_reg, c_sau_reg, c_cav_reg;
    logic signed [XW-1:0] c_c_reg, c_s_reg;
    logic signed [47:0]   c_top_reg, c_mid_reg, c_bot_reg;
    // stage D
    logic signed [85:0]   acc_t0, acc_t1;
    logic signed [55:0]   d_t0_reg, d_t1_reg;
    logic signed [XW-1:0] d_c_reg, d_s_reg;
    logic signed [47:0]   d_top_reg, d_mid_reg, d_bot_reg;
    // stage E
    logic signed [56:0]   e_ctoph_reg, e_smidh_reg, e_stoph_reg, e_cmidh_reg;
    logic signed [57:0]   e_ctopl_reg, e_smidl_reg, e_stopl_reg, e_cmidl_reg;
    logic signed [51:0]   e_t0hh_reg, e_t1hh_reg;
    logic signed [52:0]   e_t0hl_reg, e_t1hl_reg, e_t0lh_reg, e_t1lh_reg;
    logic signed [53:0]   e_t0ll_reg, e_t1ll_reg;
    logic signed [47:0]   e_bot_reg;
    // stage F
    logic signed [121:0]  f_ct_reg, f_sm_reg, f_st_reg, f_cm_reg, f_tb0_reg, f_tb1_reg;
    logic signed [47:0]   f_bot_reg;
    // stage G
    logic signed [121:0]  acc_o0, acc_o1;
    logic signed [47:0]   out_top_reg, out_mid_reg, out_bot_reg;

    assign adv     = !(vld_reg[LAT] && out_stall);
    assign pop     = adv && head_valid;
    assign divisor = (cfg.pitch == '0) ? pmru_pkg::PITCH_W'(1) : cfg.pitch;

    pmru_div u_div_u (
        .clk      (clk),
        .adv      (adv),
        .dividend (head_item.mag_u),
        .divisor  (divisor),
        .quotient (q_u)
    );

    pmru_div u_div_v (
        .clk      (clk),
        .adv      (adv),
        .dividend (head_item.mag_v),
        .divisor  (divisor),
        .quotient (q_v)
    );

    pmru_cordic #(.STAGES(CORDIC_STAGES)) u_cordic (
        .clk   (clk),
        .adv   (adv),
        .z_in  (head_item.z),
        .x_out (x_c),
        .y_out (y_c)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 1; k <= LAT; k++)
                vld_reg[k] <= 1'b0;
        end
        else if (adv)
        begin
            vld_reg[1] <= head_valid;
            for (int k = 1; k < LAT; k++)
                vld_reg[k+1] <= vld_reg[k];
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            side_reg[1] <= '{neg_u: head_item.neg_u, neg_v: head_item.neg_v,
                             flip: head_item.flip, top: head_item.top,
                             mid: head_item.mid, bot: head_item.bot};
            for (int k = 1; k < N; k++)
                side_reg[k+1] <= side_reg[k];
            xd_reg[1] <= x_c;
            yd_reg[1] <= y_c;
            for (int k = 1; k < DLY; k++)
            begin
                xd_reg[k+1] <= xd_reg[k];
                yd_reg[k+1] <= yd_reg[k];
            end
        end
    end

    always_comb
    begin
        sd     = side_reg[N];
        tu     = sd.neg_u ? $signed({1'b0, q_u}) : -$signed({1'b0, q_u});
        tv     = sd.neg_v ? $signed({1'b0, q_v}) : -$signed({1'b0, q_v});
        uc_s   = $signed({1'b0, cfg.cols, 15'd0});
        vc_s   = $signed({1'b0, cfg.rows, 15'd0});
        acc_t0 = (86'(uc_s) <<< 30) - 86'(c_cau_reg) + 86'(c_sav_reg) + T_HALF;
        acc_t1 = (86'(vc_s) <<< 30) - 86'(c_sau_reg) - 86'(c_cav_reg) + T_HALF;
        acc_o0 = f_ct_reg - f_sm_reg + (f_tb0_reg <<< 14) + O_HALF;
        acc_o1 = f_st_reg + f_cm_reg + (f_tb1_reg <<< 14) + O_HALF;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            a_c_reg   <= sd.flip ? -xd_reg[DLY] : xd_reg[DLY];
            a_s_reg   <= sd.flip ? -yd_reg[DLY] : yd_reg[DLY];
            a_au_reg  <= 50'(uc_s) + 50'(tu);
            a_av_reg  <= 50'(vc_s) + 50'(tv);
            a_top_reg <= sd.top;
            a_mid_reg <= sd.mid;
            a_bot_reg <= sd.bot;

            b_cauh_reg <= a_c_reg * $signed(a_au_reg[49:25]);
            b_caul_reg <= a_c_reg * $signed({1'b0, a_au_reg[24:0]});
            b_savh_reg <= a_s_reg * $signed(a_av_reg[49:25]);
            b_savl_reg <= a_s_reg * $signed({1'b0, a_av_reg[24:0]});
            b_sauh_reg <= a_s_reg * $signed(a_au_reg[49:25]);
            b_saul_reg <= a_s_reg * $signed({1'b0, a_au_reg[24:0]});
            b_cavh_reg <= a_c_reg * $signed(a_av_reg[49:25]);
            b_cavl_reg <= a_c_reg * $signed({1'b0, a_av_reg[24:0]});
            b_c_reg    <= a_c_reg;
            b_s_reg    <= a_s_reg;
            b_top_reg  <= a_top_reg;
            b_mid_reg  <= a_mid_reg;
            b_bot_reg  <= a_bot_reg;

            c_cau_reg <= (84'(b_cauh_reg) <<< 25) + 84'(b_caul_reg);
            c_sav_reg <= (84'(b_savh_reg) <<< 25) + 84'(b_savl_reg);
            c_sau_reg <= (84'(b_sauh_reg) <<< 25) + 84'(b_saul_reg);
            c_cav_reg <= (84'(b_cavh_reg) <<< 25) + 84'(b_cavl_reg);
            c_c_reg   <= b_c_reg;
            c_s_reg   <= b_s_reg;
            c_top_reg <= b_top_reg;
            c_mid_reg <= b_mid_reg;
            c_bot_reg <= b_bot_reg;

            d_t0_reg  <= acc_t0[85:30];
            d_t1_reg  <= acc_t1[85:30];
            d_c_reg   <= c_c_reg;
            d_s_reg   <= c_s_reg;
            d_top_reg <= c_top_reg;
            d_mid_reg <= c_mid_reg;
            d_bot_reg <= c_bot_reg;

            e_ctoph_reg <= d_c_reg * $signed(d_top_reg[47:24]);
            e_ctopl_reg <= d_c_reg * $signed({1'b0, d_top_reg[23:0]});
            e_smidh_reg <= d_s_reg * $signed(d_mid_reg[47:24]);
            e_smidl_reg <= d_s_reg * $signed({1'b0, d_mid_reg[23:0]});
            e_stoph_reg <= d_s_reg * $signed(d_top_reg[47:24]);
            e_stopl_reg <= d_s_reg * $signed({1'b0, d_top_reg[23:0]});
            e_cmidh_reg <= d_c_reg * $signed(d_mid_reg[47:24]);
            e_cmidl_reg <= d_c_reg * $signed({1'b0, d_mid_reg[23:0]});
            e_t0hh_reg  <= $signed(d_t0_reg[55:28]) * $signed(d_bot_reg[47:24]);
            e_t0hl_reg  <= $signed(d_t0_reg[55:28]) * $signed({1'b0, d_bot_reg[23:0]});
            e_t0lh_reg  <= $signed({1'b0, d_t0_reg[27:0]}) * $signed(d_bot_reg[47:24]);
            e_t0ll_reg  <= $signed({1'b0, d_t0_reg[27:0]}) * $signed({1'b0, d_bot_reg[23:0]});
            e_t1hh_reg  <= $signed(d_t1_reg[55:28]) * $signed(d_bot_reg[47:24]);
            e_t1hl_reg  <= $signed(d_t1_reg[55:28]) * $signed({1'b0, d_bot_reg[23:0]});
            e_t1lh_reg  <= $signed({1'b0, d_t1_reg[27:0]}) * $signed(d_bot_reg[47:24]);
            e_t1ll_reg  <= $signed({1'b0, d_t1_reg[27:0]}) * $signed({1'b0, d_bot_reg[23:0]});
            e_bot_reg   <= d_bot_reg;

            f_ct_reg  <= (122'(e_ctoph_reg) <<< 24) + 122'(e_ctopl_reg);
            f_sm_reg  <= (122'(e_smidh_reg) <<< 24) + 122'(e_smidl_reg);
            f_st_reg  <= (122'(e_stoph_reg) <<< 24) + 122'(e_stopl_reg);
            f_cm_reg  <= (122'(e_cmidh_reg) <<< 24) + 122'(e_cmidl_reg);
            f_tb0_reg <= (122'(e_t0hh_reg) <<< 52) + (122'(e_t0hl_reg) <<< 28)
                       + (122'(e_t0lh_reg) <<< 24) + 122'(e_t0ll_reg);
            f_tb1_reg <= (122'(e_t1hh_reg) <<< 52) + (122'(e_t1hl_reg) <<< 28)
                       + (122'(e_t1lh_reg) <<< 24) + 122'(e_t1ll_reg);
            f_bot_reg <= e_bot_reg;

            out_top_reg <= sat48(acc_o0[121:30]);
            out_mid_reg <= sat48(acc_o1[121:30]);
            out_bot_reg <= f_bot_reg;
        end
    end

    assign out_valid  = vld_reg[LAT];
    assign new_top    = out_top_reg;
    assign new_mid    = out_mid_reg;
    assign new_bottom = out_bot_reg;

endmodule

FILE: tb/pmru_checker.sv
// pmru_checker: watches the request, result and register channels of the
// projection matrix rigid update unit, predicts each corrected column and compares.
// Depends on pmru_pkg.
module pmru_checker (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           in_valid,
    input  logic                           in_stall,
    input  logic signed [31:0]             shift_u,
    input  logic signed [31:0]             shift_v,
    input  logic signed [15:0]             rot_angle,
    input  logic signed [47:0]             column_top,
    input  logic signed [47:0]             column_mid,
    input  logic signed [47:0]             column_bottom,
    input  logic                           out_valid,
    input  logic                           out_stall,
    input  logic signed [47:0]             new_top,
    input  logic signed [47:0]             new_mid,
    input  logic signed [47:0]             new_bottom,
    input  logic                           cfg_valid,
    input  logic                           cfg_ready,
    input  logic [pmru_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [pmru_pkg::PITCH_W-1:0]   cfg_data,
    output int                             fail_count,
    output int                             pending
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct {
        logic signed [47:0] top;
        logic signed [47:0] mid;
        logic signed [47:0] bot;
    } column_t;

    column_t                       corrected_columns[$];
    logic [pmru_pkg::DIM_W-1:0]    det_cols;
    logic [pmru_pkg::DIM_W-1:0]    det_rows;
    logic [pmru_pkg::PITCH_W-1:0]  pitch;

    assign pending = corrected_columns.size();

    task automatic report(input string what, input logic signed [47:0] got,
                          input logic signed [47:0] want);
        $display("%0t mismatch %s: got %0d, want %0d", $realtime, what, got, want);
        fail_count++;
    endtask

    function automatic logic signed [127:0] wide_mul(input longint a, input longint b);
        logic signed [127:0] wa;
        logic signed [127:0] wb;
        wa = a;
        wb = b;
        return wa * wb;
    endfunction

    // Q.46 sum rounded half up to Q.16, saturated to a signed width
    function automatic longint round_q16(input logic signed [127:0] v, input int bits);
        logic signed [127:0] r;
        logic signed [127:0] lim;
        r = (v + (128'sd1 <<< 29)) >>> 30;
        lim = 128'sd1 <<< (bits - 1);
        if (r > lim - 1)
            return longint'(lim - 1);
        if (r < -lim)
            return longint'(-lim);
        return longint'(r);
    endfunction

    task automatic rotation_q30(input logic signed [15:0] ang, output longint c,
                                output longint s);
        longint z;
        longint x;
        longint y;
        longint nx;
        bit     flip;
        int     stages;
        z = longint'(ang) * 131072;
        x = longint'(pmru_pkg::GAIN_INV);
        y = 0;
        flip = 0;
        stages = pmru_pkg::CORDIC_STAGES_DEF > 32 ? 32 : pmru_pkg::CORDIC_STAGES_DEF;
        if (z > longint'(pmru_pkg::Q30_HALF_PI))
        begin
            z -= longint'(pmru_pkg::Q30_PI);
            flip = 1;
        end
        else if (z < -longint'(pmru_pkg::Q30_HALF_PI))
        begin
            z += longint'(pmru_pkg::Q30_PI);
            flip = 1;
        end
        for (int i = 0; i < stages; i++)
        begin
            if (z >= 0)
            begin
                nx = x - (y >>> i);
                y = y + (x >>> i);
                z -= longint'(pmru_pkg::ATAN_Q30[i]);
            end
            else
            begin
                nx = x + (y >>> i);
                y = y - (x >>> i);
                z += longint'(pmru_pkg::ATAN_Q30[i]);
            end
            x = nx;
        end
        c = flip ? -x : x;
        s = flip ? -y : y;
    endtask

    task automatic predict_column;
        longint p, tu, tv, uc, vc, au, av, c, s, t0, t1;
        logic signed [127:0] acc;
        column_t col;
        p = pitch == 0 ? 1 : longint'(pitch);
        tu = -((longint'(shift_u) * 65536) / p);
        tv = -((longint'(shift_v) * 65536) / p);
        uc = longint'(det_cols) * 32768;
        vc = longint'(det_rows) * 32768;
        rotation_q30(rot_angle, c, s);
        au = uc + tu;
        av = vc + tv;
        acc = wide_mul(uc, 64'sd1 <<< 30) - wide_mul(c, au) + wide_mul(s, av);
        t0 = round_q16(acc, 62);
        acc = wide_mul(vc, 64'sd1 <<< 30) - wide_mul(s, au) - wide_mul(c, av);
        t1 = round_q16(acc, 62);
        acc = wide_mul(c, column_top) - wide_mul(s, column_mid)
            + (wide_mul(t0, column_bottom) <<< 14);
        col.top = 48'(round_q16(acc, 48));
        acc = wide_mul(s, column_top) + wide_mul(c, column_mid)
            + (wide_mul(t1, column_bottom) <<< 14);
        col.mid = 48'(round_q16(acc, 48));
        col.bot = column_bottom;
        corrected_columns.push_back(col);
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        column_t want;
        if (!rst_n)
        begin
            det_cols = pmru_pkg::COLS_RESET;
            det_rows = pmru_pkg::ROWS_RESET;
            pitch = pmru_pkg::PITCH_RESET;
            fail_count = 0;
            corrected_columns.delete();
        end
        else
        begin
            if (out_valid && !out_stall)
            begin
                if (corrected_columns.size() == 0)
                begin
                    $display("%0t unexpected result", $realtime);
                    fail_count++;
                end
                else
                begin
                    want = corrected_columns.pop_front();
                    if (new_top !== want.top)
                        report("new_top", new_top, want.top);
                    if (new_mid !== want.mid)
                        report("new_mid", new_mid, want.mid);
                    if (new_bottom !== want.bot)
                        report("new_bottom", new_bottom, want.bot);
                end
            end
            if (in_valid && !in_stall)
                predict_column();
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    pmru_pkg::CFG_COLS:  det_cols = cfg_data[pmru_pkg::DIM_W-1:0];
                    pmru_pkg::CFG_ROWS:  det_rows = cfg_data[pmru_pkg::DIM_W-1:0];
                    pmru_pkg::CFG_PITCH: pitch = cfg_data;
                    default:   ;
                endcase
            end
        end
    end
endmodule

FILE: tb/tb_projection_matrix_rigid_update_unit.sv
// tb_projection_matrix_rigid_update_unit: drives requests, register writes and
// result back-pressure into the unit; checking is done by pmru_checker.
// Depends on pmru_pkg, projection_matrix_rigid_update_unit and pmru_checker.
module tb_projection_matrix_rigid_update_unit;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int SETTLE_CYCLES = 80;
    localparam int CYCLE_LIMIT   = 600000;

    logic clk = 0;
    logic rst_n = 0;
    logic in_valid = 0;
    logic in_stall;
    logic signed [31:0] shift_u = 0;
    logic signed [31:0] shift_v = 0;
    logic signed [15:0] rot_angle = 0;
    logic signed [47:0] column_top = 0;
    logic signed [47:0] column_mid = 0;
    logic signed [47:0] column_bottom = 0;
    logic out_valid;
    logic out_stall = 0;
    logic signed [47:0] new_top;
    logic signed [47:0] new_mid;
    logic signed [47:0] new_bottom;
    logic cfg_valid = 0;
    logic cfg_ready;
    logic [pmru_pkg::CFG_IDX_W-1:0] cfg_index = pmru_pkg::CFG_COLS;
    logic [pmru_pkg::PITCH_W-1:0]   cfg_data = 0;
    int fail_count;
    int pending;
    int sender_idle_pct = 0;
    int receiver_idle_pct = 0;
    int cycles = 0;

    always
    begin
        #5 clk = 1;
        #5 clk = 0;
    end

    projection_matrix_rigid_update_unit u_dut (.*);

    pmru_checker u_checker (.*);

    always @(negedge clk)
        out_stall <= ($urandom_range(99) < receiver_idle_pct);

    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("RESULT: ERROR");
            $finish;
        end
    end

    task automatic send_request(input logic signed [31:0] su, input logic signed [31:0] sv,
                                input logic signed [15:0] ang, input logic signed [47:0] t,
                                input logic signed [47:0] m, input logic signed [47:0] b);
        while ($urandom_range(99) < sender_idle_pct)
        begin
            in_valid = 0;
            @(negedge clk);
        end
        shift_u = su;
        shift_v = sv;
        rot_angle = ang;
        column_top = t;
        column_mid = m;
        column_bottom = b;
        in_valid = 1;
        do
            @(posedge clk);
        while (in_stall);
        @(negedge clk);
    endtask

    task automatic drain;
        in_valid = 0;
        while (pending != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    task automatic write_reg(input logic [pmru_pkg::CFG_IDX_W-1:0] idx,
                             input logic [pmru_pkg::PITCH_W-1:0] val);
        cfg_index = idx;
        cfg_data = val;
        cfg_valid = 1;
        do
            @(posedge clk);
        while (!cfg_ready);
        @(negedge clk);
        cfg_valid = 0;
    endtask

    function automatic logic [47:0] rand48(input int mode);
        logic [47:0] v;
        v = {$urandom(), $urandom()};
        case (mode)
            0: return 48'(signed'(v[23:0]));
            1: return 48'(signed'(v[35:0]));
            default: return v;
        endcase
    endfunction

    task automatic random_request;
        logic signed [31:0] su;
        logic signed [31:0] sv;
        logic signed [15:0] ang;
        su = $urandom_range(3) == 0 ? $urandom() : 32'(signed'($urandom_range(0, 1 << 22)))
            - (1 << 21);
        sv = $urandom_range(3) == 0 ? $urandom() : 32'(signed'($urandom_range(0, 1 << 22)))
            - (1 << 21);
        ang = $urandom_range(7) == 0 ? 16'($urandom()) : 16'($urandom_range(0, 51472) - 25736);
        send_request(su, sv, ang, rand48($urandom_range(2)), rand48($urandom_range(2)),
                     $urandom_range(7) == 0 ? 48'sd0 : rand48($urandom_range(2)));
    endtask

    initial
    begin
        int phase_items;
        phase_items = 325;
        repeat (5) @(negedge clk);
        rst_n = 1;
        @(negedge clk);

        // directed: field extremes, angle folds, full-range angles, saturation
        send_request(0, 0, 0, 48'sd65536, 48'sd65536, 48'sd65536);
        send_request(32'sh7FFFFFFF, 32'sh80000000, 16'sd25736,
                     48'sh7FFFFFFFFFFF, 48'sh800000000000, 48'sh7FFFFFFFFFFF);
        send_request(32'sh80000000, 32'sh7FFFFFFF, -16'sd25736,
                     48'sh800000000000, 48'sh7FFFFFFFFFFF, 48'sh800000000000);
        send_request(65536, -65536, 16'sd12868, 48'sd1 <<< 20, -48'sd1 <<< 20, 48'sd65536);
        send_request(-65536, 65536, 16'sd12869, 48'sd12345, 48'sd54321, 48'sd65536);
        send_request(1, -1, -16'sd12869, 48'sd100, -48'sd100, 48'sd1);
        send_request(0, 0, 16'sh7FFF, 48'sd65536, 0, 48'sd65536);
        send_request(0, 0, 16'sh8000, 0, 48'sd65536, 48'sd65536);
        send_request(-1, -1, -16'sd1, -48'sd1, -48'sd1, -48'sd1);
        send_request(32'hFFFFFFFF, 0, 16'sd1, 48'hFFFFFFFFFFFF, 48'h555555555555, 48'sd0);
        send_request(32'h55555555, 32'hAAAAAAAA, 16'sh5555,
                     48'hAAAAAAAAAAAA, 48'h555555555555, 48'hAAAAAAAAAAAA);
        send_request(32'hAAAAAAAA, 32'h55555555, 16'shAAAA,
                     48'h555555555555, 48'hAAAAAAAAAAAA, 48'h555555555555);
        drain();

        // zero and extreme geometry, zero pitch, ignored index
        write_reg(pmru_pkg::CFG_COLS, 0);
        write_reg(pmru_pkg::CFG_ROWS, 24'h1FFF);
        write_reg(pmru_pkg::CFG_PITCH, 0);
        write_reg(pmru_pkg::CFG_SPARE, 24'hFFFFFF);
        send_request(32'sh7FFFFFFF, 32'sh80000000, 16'sd100,
                     48'sh7FFFFFFFFFFF, 48'sh7FFFFFFFFFFF, 48'sh7FFFFFFFFFFF);
        send_request(32'sh80000000, 32'sh7FFFFFFF, -16'sd100,
                     48'sh800000000000, 48'sh800000000000, 48'sh800000000000);
        send_request(1, 1, 16'sd25736, 48'sd65536, 48'sd65536, 48'sd65536);
        drain();

        for (int phase = 0; phase < 6; phase++)
        begin
            case (phase)
                0:
                begin
                    write_reg(pmru_pkg::CFG_COLS, 1024);
                    write_reg(pmru_pkg::CFG_ROWS, 768);
                    write_reg(pmru_pkg::CFG_PITCH, 6554);
                end
                1:
                begin
                    write_reg(pmru_pkg::CFG_COLS, 1);
                    write_reg(pmru_pkg::CFG_ROWS, 1);
                    write_reg(pmru_pkg::CFG_PITCH, 1);
                end
                2:
                begin
                    write_reg(pmru_pkg::CFG_COLS, 4096);
                    write_reg(pmru_pkg::CFG_ROWS, 4096);
                    write_reg(pmru_pkg::CFG_PITCH, 24'hFFFFFF);
                end
                3:
                begin
                    write_reg(pmru_pkg::CFG_COLS, 24'($urandom_range(1, 4096)));
                    write_reg(pmru_pkg::CFG_ROWS, 24'($urandom_range(1, 4096)));
                    write_reg(pmru_pkg::CFG_PITCH, 24'($urandom_range(1, 24'hFFFFFF)));
                end
                4:
                begin
                    write_reg(pmru_pkg::CFG_COLS, 24'($urandom()));
                    write_reg(pmru_pkg::CFG_ROWS, 24'($urandom()));
                    write_reg(pmru_pkg::CFG_PITCH, 24'($urandom()));
                end
                default:
                begin
                    write_reg(pmru_pkg::CFG_COLS, 2048);
                    write_reg(pmru_pkg::CFG_ROWS, 1536);
                    write_reg(pmru_pkg::CFG_PITCH, 9830);
                end
            endcase
            for (int n = 0; n < phase_items; n++)
            begin
                if (n < phase_items / 3)
                begin
                    sender_idle_pct = 20;
                    receiver_idle_pct = 85;
                end
                else if (n < 2 * phase_items / 3)
                begin
                    sender_idle_pct = 85;
                    receiver_idle_pct = 20;
                end
                else
                begin
                    sender_idle_pct = 0;
                    receiver_idle_pct = 0;
                end
                // hold requests back until the pipeline has emptied
                if (n == phase_items / 2)
                begin
                    in_valid = 0;
                    while (pending != 0)
                        @(negedge clk);
                end
                random_request();
            end
            drain();
        end

        if (fail_count == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end
endmodule
